@@ rtl/core/integer_to_padded_text_core_assert.svh @@
// assertion macros used by the integer-to-text core
`ifndef INTEGER_TO_PADDED_TEXT_CORE_ASSERT_SVH
`define INTEGER_TO_PADDED_TEXT_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ITPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itpt check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ITPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itpt check failed");

`endif

@@ rtl/core/itpt_pkg.sv @@
// shared types, constants and the digit-to-ascii function of the integer-to-text core
package itpt_pkg;

    localparam int MAG_W      = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int PTR_W      = $clog2(NUM_DIGITS);
    localparam int CHAR_W     = 7;
    localparam int POS_W      = 6;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 16;

    localparam logic [PTR_W-1:0] TOP_DEC = PTR_W'(NUM_DIGITS - 1);
    localparam logic [PTR_W-1:0] TOP_HEX = PTR_W'(MAG_W / DIGIT_W - 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PREP,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10))
            return CHAR_ZERO + ext;
        else
            return CHAR_A + ext - CHAR_W'(10);
    endfunction

endpackage

@@ rtl/core/itpt_dabble.sv @@
// binary to bcd converter, one shift-and-add-3 step per cycle
module itpt_dabble
    import itpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] value,
    output logic             done,
    output digits_t          bcd
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]  bin_reg, bin_next;
    digits_t           bcd_reg, bcd_next;
    digits_t           bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] >= DIGIT_W'(5))
                bcd_adj[i] = bcd_reg[i] + DIGIT_W'(3);
            else
                bcd_adj[i] = bcd_reg[i];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = value;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = digits_t'({bcd_adj, bin_reg[MAG_W-1]});
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ rtl/core/integer_to_padded_text_core.sv @@
// sequence: hex scans up to 16 digits and then a setup state before the first character;
//   decimal first runs the bcd conversion (one bit per cycle) and scans up to 20 digits
// throughput: one character per cycle while not stalled, max(field_width, digits + sign)
//   in all; the next item is taken only once the last character is in the output register
// reset: rst_n clears the sequencer and output valid asynchronously, data registers hold
`include "integer_to_padded_text_core_assert.svh"
module integer_to_padded_text_core
    import itpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // magnitude[63:0], negative, radix_hex, field_width[5:0], zero_pad, left_justify, zeros
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // character[6:0], position[5:0], zeros
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    state_t            state_reg, state_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic              left_reg, left_next;
    logic [POS_W-1:0]  width_reg, width_next;
    digits_t           digits_reg, digits_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [POS_W-1:0]  np_reg, np_next;
    logic [POS_W-1:0]  ds_reg, ds_next;
    logic [POS_W-1:0]  de_reg, de_next;
    logic [POS_W-1:0]  lastpos_reg, lastpos_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              in_hex;
    logic              dab_start;
    logic              dab_done;
    digits_t           dab_bcd;
    logic              scan_stop;
    logic              load;
    logic              in_digits;
    logic [POS_W-1:0]  nd;
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  pad;
    logic [POS_W-1:0]  neg_ext;
    logic [CHAR_W-1:0] pad_char;

    itpt_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .value (s_axis_tdata[MAG_W-1:0]),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_hex        = s_axis_tdata[65];
    assign dab_start     = accept && !in_hex;
    assign scan_stop     = (digits_reg[ptr_reg] != '0) || (ptr_reg == '0);
    assign load          = !out_valid_reg || m_axis_tready;
    assign in_digits     = (pos_reg >= ds_reg) && (pos_reg < de_reg);

    // run layout from digit count, sign and width
    assign nd      = {{(POS_W - PTR_W){1'b0}}, ptr_reg} + POS_W'(1);
    assign neg_ext = {{(POS_W - 1){1'b0}}, neg_reg};
    assign len     = nd + neg_ext;
    assign pad     = (width_reg > len) ? (width_reg - len) : '0;
    assign pad_char = (zero_reg && !left_reg) ? CHAR_ZERO : CHAR_SPACE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = in_hex ? ST_SCAN : ST_CONV;
            end
            ST_CONV:
            begin
                if (dab_done)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_stop)
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load && (pos_reg == lastpos_reg))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        left_next      = left_reg;
        width_next     = width_reg;
        digits_next    = digits_reg;
        ptr_next       = ptr_reg;
        np_next        = np_reg;
        ds_next        = ds_reg;
        de_next        = de_reg;
        lastpos_next   = lastpos_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = s_axis_tdata[64];
                    width_next = s_axis_tdata[71:66];
                    zero_next  = s_axis_tdata[72];
                    left_next  = s_axis_tdata[73];
                    digits_next = digits_t'({{(NUM_DIGITS * DIGIT_W - MAG_W){1'b0}},
                                             s_axis_tdata[MAG_W-1:0]});
                    ptr_next   = in_hex ? TOP_HEX : TOP_DEC;
                end
            end
            ST_CONV:
            begin
                if (dab_done)
                    digits_next = dab_bcd;
            end
            ST_SCAN:
            begin
                if (!scan_stop)
                    ptr_next = ptr_reg - PTR_W'(1);
            end
            ST_PREP:
            begin
                np_next      = (!left_reg && !zero_reg) ? pad : '0;
                ds_next      = left_reg ? neg_ext : (pad + neg_ext);
                de_next      = (left_reg ? neg_ext : (pad + neg_ext)) + nd;
                lastpos_next = ((width_reg > len) ? width_reg : len) - POS_W'(1);
                pos_next     = '0;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_last_next  = (pos_reg == lastpos_reg);
                    pos_next       = pos_reg + POS_W'(1);
                    if (neg_reg && (pos_reg == np_reg))
                        out_char_next = CHAR_MINUS;
                    else if (in_digits)
                    begin
                        out_char_next = digit_char(digits_reg[ptr_reg]);
                        ptr_next      = ptr_reg - PTR_W'(1);
                    end
                    else
                        out_char_next = pad_char;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        left_reg     <= left_next;
        width_reg    <= width_next;
        digits_reg   <= digits_next;
        ptr_reg      <= ptr_next;
        np_reg       <= np_next;
        ds_reg       <= ds_next;
        de_reg       <= de_next;
        lastpos_reg  <= lastpos_next;
        pos_reg      <= pos_next;
        out_char_reg <= out_char_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - CHAR_W - POS_W){1'b0}}, out_pos_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    `ITPT_ASSERT_SAME(a_pos_in_run, state_reg == ST_EMIT, pos_reg <= lastpos_reg)
    `ITPT_ASSERT_SAME(a_done_while_conv, dab_done, state_reg == ST_CONV)
    `ITPT_ASSERT_SAME(a_digit_ptr_range, (state_reg == ST_EMIT) && in_digits,
                      ptr_reg < PTR_W'(NUM_DIGITS))
    `ITPT_ASSERT_NEXT(a_run_continues,
                      m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                      m_axis_tvalid && (out_pos_reg == $past(out_pos_reg) + POS_W'(1)))

endmodule

@@ test/padded_text_checker.sv @@
`timescale 1ns / 100ps
// checker for the integer-to-text core: predicts each number's characters and compares them
module padded_text_checker
    import itpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic                m_axis_tlast,
    output int                  mismatch_count,
    output int                  chars_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [POS_W-1:0]  index;
        logic              tail;
    } text_char_t;

    text_char_t expected_chars[$];
    text_char_t got;
    text_char_t want;
    int         fails = 0;

    // appends the characters that one number should produce
    function automatic void format_number(input logic [MAG_W-1:0] mag, input logic neg,
                                          input logic hex, input logic [5:0] fw,
                                          input logic zp, input logic lj);
        logic [CHAR_W-1:0] digits[$];
        logic [CHAR_W-1:0] text[$];
        logic [MAG_W-1:0]  v;
        logic [MAG_W-1:0]  base;
        logic [3:0]        d;
        logic [CHAR_W-1:0] c;
        text_char_t        entry;
        int                len;
        int                pad;
        base = hex ? 64'd16 : 64'd10;
        v = mag;
        if (v == 0)
            digits.push_front(CHAR_ZERO);
        // least significant digit first, pushed to the front so the queue reads msd first
        while (v != 0)
        begin
            d = 4'(v % base);
            c = (d < 4'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d) - 7'd10;
            digits.push_front(c);
            v = v / base;
        end
        len = digits.size() + (neg ? 1 : 0);
        pad = (int'(fw) > len) ? int'(fw) - len : 0;
        if (!lj && !zp)
            repeat (pad) text.push_back(CHAR_SPACE);
        // sign goes ahead of zero padding
        if (neg)
            text.push_back(CHAR_MINUS);
        if (!lj && zp)
            repeat (pad) text.push_back(CHAR_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
        if (lj)
            repeat (pad) text.push_back(CHAR_SPACE);
        foreach (text[k])
        begin
            entry.code  = text[k];
            entry.index = POS_W'(k);
            entry.tail  = (k == text.size() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // output side first: a character never belongs to an item taken in the same cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.code  = m_axis_tdata[CHAR_W-1:0];
                got.index = m_axis_tdata[CHAR_W +: POS_W];
                got.tail  = m_axis_tlast;
                if (expected_chars.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected character %h position %0d last %b",
                                 got.code, got.index, got.tail);
                    fails++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (got.code !== want.code || got.index !== want.index
                        || got.tail !== want.tail)
                    begin
                        if (fails < 10)
                            $display(
                                "mismatch: expected %h pos %0d last %b, got %h pos %0d last %b",
                                want.code, want.index, want.tail,
                                got.code, got.index, got.tail);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                format_number(s_axis_tdata[MAG_W-1:0], s_axis_tdata[64], s_axis_tdata[65],
                              s_axis_tdata[71:66], s_axis_tdata[72], s_axis_tdata[73]);
        end
        mismatch_count <= fails;
        chars_pending  <= expected_chars.size();
    end

endmodule

@@ test/tb_integer_to_padded_text_core.sv @@
`timescale 1ns / 100ps
// testbench top for the integer-to-text core: clock, reset, number stimulus and verdict
module tb_integer_to_padded_text_core;
    import itpt_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int HOLD_LEN         = 400;
    localparam int DRAIN_CYCLES     = 150;
    localparam int RANDOM_PER_PHASE = 120;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    int   mismatch_count;
    int   chars_pending;
    int   source_idle_pct = 0;
    int   sink_idle_pct;
    logic hold_armed;
    int   cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    integer_to_padded_text_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    padded_text_checker text_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_integer_to_padded_text_core NOT OK");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off once armed
    initial
    begin
        int held;
        held = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && held < HOLD_LEN)
            begin
                held++;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_number(input logic [MAG_W-1:0] mag, input logic neg, input logic hex,
                               input logic [5:0] fw, input logic zp, input logic lj);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        // tdata: magnitude, negative, radix_hex, field_width, zero_pad, left_justify
        s_axis_tdata  <= S_DATA_W'({lj, zp, fw, hex, neg, mag});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic random_number();
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] pow;
        logic [5:0]       fw;
        int               pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1: mag = MAG_W'($urandom_range(255));
            2, 3: mag = {$urandom, $urandom};
            4, 5: mag = {$urandom, $urandom} >> $urandom_range(63);
            6:
            begin
                // around a power of ten, where the digit count changes
                pow = 64'd1;
                repeat ($urandom_range(19)) pow = pow * 64'd10;
                mag = pow + MAG_W'($urandom_range(2)) - 64'd1;
            end
            7: mag = (64'd1 << (4 * $urandom_range(15))) - MAG_W'($urandom_range(1));
            8: mag = {64{1'b1}} >> $urandom_range(63);
            default: mag = '0;
        endcase
        fw = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(24));
        send_number(mag, 1'($urandom_range(1)), 1'($urandom_range(1)), fw,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        hold_armed    <= 1'b0;
        sink_idle_pct <= 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        source_idle_pct = 15;
        sink_idle_pct  <= 62;

        // directed: zero, extremes, padding styles and their interactions
        send_number(64'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number(64'd0, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number({64{1'b1}}, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number({64{1'b1}}, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0);
        send_number({64{1'b1}}, 1'b1, 1'b0, 6'd63, 1'b1, 1'b0);
        send_number(64'hdead_beef, 1'b1, 1'b1, 6'd12, 1'b1, 1'b0);
        send_number(64'd12345, 1'b1, 1'b0, 6'd20, 1'b0, 1'b1);
        send_number(64'd42, 1'b0, 1'b0, 6'd15, 1'b1, 1'b1);
        send_number(64'd0, 1'b0, 1'b0, 6'd63, 1'b0, 1'b0);
        send_number(64'd12345, 1'b0, 1'b0, 6'd3, 1'b0, 1'b0);
        send_number(64'd7, 1'b0, 1'b1, 6'd63, 1'b0, 1'b1);
        send_number(64'd9, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number(64'd10, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number(64'd15, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0);
        send_number(64'd16, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0);
        send_number(64'd10000000000000000000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
        send_number(64'd9999999999999999999, 1'b1, 1'b0, 6'd25, 1'b0, 1'b0);
        send_number(64'h8000_0000_0000_0000, 1'b1, 1'b1, 6'd17, 1'b1, 1'b0);
        send_number(64'd99, 1'b0, 1'b0, 6'd2, 1'b1, 1'b0);
        send_number(64'd5, 1'b1, 1'b0, 6'd1, 1'b1, 1'b0);
        send_number(64'd1, 1'b0, 1'b1, 6'd63, 1'b1, 1'b0);

        repeat (RANDOM_PER_PHASE) random_number();

        source_idle_pct = 62;
        sink_idle_pct  <= 15;
        repeat (RANDOM_PER_PHASE) random_number();

        // no idling; the receiver's long hold-off backs the core up into its input
        source_idle_pct = 0;
        sink_idle_pct  <= 0;
        hold_armed     <= 1'b1;
        repeat (RANDOM_PER_PHASE) random_number();

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && chars_pending == 0)
            $display("tb_integer_to_padded_text_core OK");
        else
            $display("tb_integer_to_padded_text_core NOT OK");
        $finish;
    end

endmodule
